// ===== rtl/assert_macros.svh =====
// assertion helpers, included by task_starvation_monitor.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// clocked check, off while reset is asserted
`define TSM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m: check failed");
// clocked check that also holds during reset
`define TSM_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define TSM_ASSERT(lbl, clk, rst_n, prop)
`define TSM_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/tsm_pkg.sv =====
package tsm_pkg;

	// parameter defaults
	localparam int TASKS_DEF     = 64;
	localparam int WAIT_BITS_DEF = 16;

	// fixed field widths
	localparam int OP_W       = 2;
	localparam int SLOT_W     = 6;
	localparam int PREV_W     = 17;
	localparam int BARRIER_W  = 17;
	localparam int LWAIT_W    = 16;
	localparam int WORST_W    = 6;
	localparam int ROUND_W    = 32;
	localparam int ACTIVE_W   = 7;
	localparam int BOUND_W    = 16;
	localparam int ALIVE_W    = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TASKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAIT_BOUND   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALIVE_TASKS  = 2'd2;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR   = 2'd0,
		OP_POLL    = 2'd1,
		OP_ADVANCE = 2'd2,
		OP_EVAL    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// control from the sequencer to the head unit
	typedef struct packed {
		logic              en;
		logic              first;
		op_t               op;
		logic [SLOT_W-1:0] slot;
	} head_ctl_t;

endpackage

// ===== rtl/tsm_if.sv =====
interface tsm_cmd_if;
	logic                                   valid;
	logic                                   ready;
	tsm_pkg::op_t                           op;
	logic [tsm_pkg::SLOT_W-1:0]             task_slot;
	logic signed [tsm_pkg::PREV_W-1:0]      previous_value;

	modport source(output valid, op, task_slot, previous_value, input ready);
	modport sink(input valid, op, task_slot, previous_value, output ready);
endinterface

interface tsm_rsp_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [tsm_pkg::BARRIER_W-1:0]   barrier_value;
	logic                                   is_safe;
	logic                                   is_decreasing;
	logic [tsm_pkg::LWAIT_W-1:0]            largest_wait;
	logic [tsm_pkg::WORST_W-1:0]            worst_task;
	logic                                   bound_admissible;
	logic [tsm_pkg::ROUND_W-1:0]            round_number;

	modport source(output valid, barrier_value, is_safe, is_decreasing, largest_wait,
		worst_task, bound_admissible, round_number, input ready);
	modport sink(input valid, barrier_value, is_safe, is_decreasing, largest_wait,
		worst_task, bound_admissible, round_number, output ready);
endinterface

interface tsm_cfg_if;
	logic                                   valid;
	logic                                   ready;
	logic [tsm_pkg::CFG_IDX_W-1:0]          index;
	logic [tsm_pkg::CFG_DATA_W-1:0]         data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/tsm_cell.sv =====
module tsm_cell #(
	parameter int WAIT_BITS = tsm_pkg::WAIT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 shift_en,
	input  logic [WAIT_BITS-1:0] wait_d,
	output logic [WAIT_BITS-1:0] wait_q
);

	// one task's wait counter, takes its neighbor's value on each shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q <= '0;
		end else if (shift_en) begin
			wait_q <= wait_d;
		end
	end

endmodule

// ===== rtl/tsm_head.sv =====
module tsm_head #(
	parameter int TASKS     = tsm_pkg::TASKS_DEF,
	parameter int WAIT_BITS = tsm_pkg::WAIT_BITS_DEF,
	localparam int IDX_W    = (TASKS > 1) ? $clog2(TASKS) : 1,
	localparam int CNT_W    = $clog2(TASKS + 1),
	localparam int CMP_W    = (CNT_W > tsm_pkg::ACTIVE_W) ? CNT_W : tsm_pkg::ACTIVE_W
) (
	input  logic                 clk,
	input  tsm_pkg::head_ctl_t   ctl,
	input  logic [IDX_W-1:0]     step,
	input  logic [CMP_W-1:0]     n_active,
	input  logic [WAIT_BITS-1:0] wait_in,
	output logic [WAIT_BITS-1:0] wait_out,
	output logic [WAIT_BITS-1:0] peak_wait,
	output logic [IDX_W-1:0]     worst_idx
);

	logic [CMP_W-1:0]     step_c;
	logic [CMP_W-1:0]     slot_c;
	logic                 in_range;
	logic [WAIT_BITS-1:0] base_max;
	logic [IDX_W-1:0]     base_worst;
	logic [WAIT_BITS-1:0] max_q;
	logic [IDX_W-1:0]     worst_q;

	assign step_c   = CMP_W'(step);
	assign slot_c   = CMP_W'(ctl.slot);
	assign in_range = step_c < n_active;

	// update of the counter passing the head
	always_comb begin
		unique case (ctl.op)
			tsm_pkg::OP_CLEAR: begin
				wait_out = '0;
			end
			tsm_pkg::OP_POLL: begin
				wait_out = (in_range && slot_c == step_c) ? '0 : wait_in;
			end
			tsm_pkg::OP_ADVANCE: begin
				wait_out = (in_range && wait_in != '1) ? wait_in + 1'b1 : wait_in;
			end
			tsm_pkg::OP_EVAL: begin
				wait_out = wait_in;
			end
		endcase
	end

	// running max restarts at the first step; strict compare keeps the lowest index
	assign base_max   = ctl.first ? '0 : max_q;
	assign base_worst = ctl.first ? '0 : worst_q;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			if (in_range && wait_out > base_max) begin
				max_q   <= wait_out;
				worst_q <= step;
			end else begin
				max_q   <= base_max;
				worst_q <= base_worst;
			end
		end
	end

	assign peak_wait = max_q;
	assign worst_idx = worst_q;

endmodule

// ===== rtl/task_starvation_monitor.sv =====
// Starvation monitor for up to TASKS tasks. Each command word (clear, poll, advance round,
// evaluate) is followed by exactly one result word with the largest active wait, the lowest
// task holding it, the barrier value, safety/decrease/admissibility flags and the round count.
// The per-task wait counters sit in a ring of cells that rotates one counter per cycle
// through a single head unit, which applies the operation and tracks the running maximum;
// the done state then forms the result. The result sits in an output register, so the next
// command is taken while an earlier result waits for rsp.ready.
// Configuration writes (cfg) are always accepted and must only come while no command is in
// flight.
`include "assert_macros.svh"

module task_starvation_monitor #(
	parameter int TASKS     = tsm_pkg::TASKS_DEF,
	parameter int WAIT_BITS = tsm_pkg::WAIT_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tsm_cmd_if.sink   cmd,
	tsm_rsp_if.source rsp,
	tsm_cfg_if.sink   cfg
);

	localparam int IDX_W   = (TASKS > 1) ? $clog2(TASKS) : 1;
	localparam int CNT_W   = $clog2(TASKS + 1);
	localparam int CMP_W   = (CNT_W > tsm_pkg::ACTIVE_W) ? CNT_W : tsm_pkg::ACTIVE_W;
	// barrier math wide enough for bound minus the widest counter
	localparam int VAL_W   = ((WAIT_BITS > tsm_pkg::BOUND_W) ? WAIT_BITS : tsm_pkg::BOUND_W) + 2;
	localparam int LW_EXT_W =
		(WAIT_BITS > tsm_pkg::LWAIT_W) ? WAIT_BITS : tsm_pkg::LWAIT_W;
	localparam int WK_EXT_W = (IDX_W > tsm_pkg::WORST_W) ? IDX_W : tsm_pkg::WORST_W;
	localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(TASKS - 1);

	// configuration registers
	logic [tsm_pkg::ACTIVE_W-1:0] active_q;
	logic [tsm_pkg::BOUND_W-1:0]  bound_q;
	logic [tsm_pkg::ALIVE_W-1:0]  alive_q;

	// latched command word
	tsm_pkg::op_t                      op_q;
	logic [tsm_pkg::SLOT_W-1:0]        slot_q;
	logic signed [tsm_pkg::PREV_W-1:0] prev_q;
	logic [tsm_pkg::ROUND_W-1:0]       round_q;

	// sequencer
	tsm_pkg::state_t  state_q;
	tsm_pkg::state_t  state_d;
	logic [IDX_W-1:0] step_q;
	logic             cmd_take;
	logic             scan_en;
	logic             rsp_load;

	// ring of cells and head unit
	logic [WAIT_BITS-1:0] wait_q [TASKS];
	logic [WAIT_BITS-1:0] wait_tail;
	logic [WAIT_BITS-1:0] peak_wait;
	logic [IDX_W-1:0]     worst_idx;
	logic [CMP_W-1:0]     active_c;
	logic [CMP_W-1:0]     n_active;
	tsm_pkg::head_ctl_t   head_ctl;

	// result forming
	logic signed [VAL_W-1:0] value_c;
	logic signed [VAL_W-1:0] prev_ext;
	logic [LW_EXT_W-1:0]     max_ext;
	logic [WK_EXT_W-1:0]     worst_ext;

	// output register
	logic                                 rsp_valid_q;
	logic signed [tsm_pkg::BARRIER_W-1:0] barrier_q;
	logic                                 safe_q;
	logic                                 decr_q;
	logic [tsm_pkg::LWAIT_W-1:0]          lwait_q;
	logic [tsm_pkg::WORST_W-1:0]          worst_q;
	logic                                 admit_q;
	logic [tsm_pkg::ROUND_W-1:0]          rnum_q;

	// effective task count, clamped to capacity
	assign active_c = CMP_W'(active_q);
	assign n_active = (active_c > CMP_W'(TASKS)) ? CMP_W'(TASKS) : active_c;

	// config writes, index beyond the list is dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			bound_q  <= '0;
			alive_q  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				tsm_pkg::REG_ACTIVE_TASKS: active_q <= cfg.data[tsm_pkg::ACTIVE_W-1:0];
				tsm_pkg::REG_WAIT_BOUND:   bound_q  <= cfg.data[tsm_pkg::BOUND_W-1:0];
				tsm_pkg::REG_ALIVE_TASKS:  alive_q  <= cfg.data[tsm_pkg::ALIVE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and strobes
	always_comb begin
		state_d   = state_q;
		cmd.ready = 1'b0;
		scan_en   = 1'b0;
		rsp_load  = 1'b0;
		unique case (state_q)
			tsm_pkg::ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					state_d = tsm_pkg::ST_SCAN;
				end
			end
			tsm_pkg::ST_SCAN: begin
				scan_en = 1'b1;
				if (step_q == LAST_STEP) begin
					state_d = tsm_pkg::ST_DONE;
				end
			end
			tsm_pkg::ST_DONE: begin
				// wait here until the output register is free
				if (!rsp_valid_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = tsm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tsm_pkg::ST_IDLE;
			end
		endcase
	end

	assign cmd_take = cmd.valid && cmd.ready;

	// step counter: index of the task currently at the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (scan_en) begin
			step_q <= (step_q == LAST_STEP) ? '0 : step_q + 1'b1;
		end
	end

	// round counter updates as soon as the command is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= '0;
		end else if (cmd_take) begin
			if (cmd.op == tsm_pkg::OP_CLEAR) begin
				round_q <= '0;
			end else if (cmd.op == tsm_pkg::OP_ADVANCE) begin
				round_q <= round_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			op_q   <= cmd.op;
			slot_q <= cmd.task_slot;
			prev_q <= cmd.previous_value;
		end
	end

	// ring: cell 0 feeds the head, the head's updated value enters at the tail
	for (genvar i = 0; i < TASKS; i++) begin : g_ring
		if (i == TASKS - 1) begin : g_tail
			tsm_cell #(.WAIT_BITS(WAIT_BITS)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (scan_en),
				.wait_d   (wait_tail),
				.wait_q   (wait_q[i])
			);
		end else begin : g_mid
			tsm_cell #(.WAIT_BITS(WAIT_BITS)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (scan_en),
				.wait_d   (wait_q[i+1]),
				.wait_q   (wait_q[i])
			);
		end
	end

	assign head_ctl = '{en: scan_en, first: (step_q == '0), op: op_q, slot: slot_q};

	tsm_head #(.TASKS(TASKS), .WAIT_BITS(WAIT_BITS)) u_head (
		.clk       (clk),
		.ctl       (head_ctl),
		.step      (step_q),
		.n_active  (n_active),
		.wait_in   (wait_q[0]),
		.wait_out  (wait_tail),
		.peak_wait (peak_wait),
		.worst_idx (worst_idx)
	);

	// barrier value and flags from the finished scan
	assign value_c   = $signed(VAL_W'(bound_q)) - $signed(VAL_W'(peak_wait));
	assign prev_ext  = VAL_W'(prev_q);
	assign max_ext   = LW_EXT_W'(peak_wait);
	assign worst_ext = WK_EXT_W'(worst_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			barrier_q <= value_c[tsm_pkg::BARRIER_W-1:0];
			safe_q    <= !value_c[VAL_W-1] && (value_c != '0);
			decr_q    <= value_c < prev_ext;
			lwait_q   <= max_ext[tsm_pkg::LWAIT_W-1:0];
			worst_q   <= worst_ext[tsm_pkg::WORST_W-1:0];
			admit_q   <= (bound_q != '0) && (CMP_W'(alive_q) <= n_active);
			rnum_q    <= round_q;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.barrier_value    = barrier_q;
	assign rsp.is_safe          = safe_q;
	assign rsp.is_decreasing    = decr_q;
	assign rsp.largest_wait     = lwait_q;
	assign rsp.worst_task       = worst_q;
	assign rsp.bound_admissible = admit_q;
	assign rsp.round_number     = rnum_q;

	// a taken command always starts its scan with task 0 at the head
	`TSM_ASSERT(a_scan_starts_at_zero, clk, arst_n, cmd_take |=> (scan_en && step_q == '0))
	// no wait anywhere means the reported task is 0
	`TSM_ASSERT(a_zero_wait_worst, clk, arst_n, (rsp_load && peak_wait == '0) |-> worst_idx == '0)
	// a new result only appears out of the done state
	`TSM_ASSERT(a_result_after_scan, clk, arst_n, $rose(rsp_valid_q) |-> $past(rsp_load))
	// ring is back in place whenever no scan runs
	`TSM_ASSERT_ALWAYS(a_idle_step_zero, clk, (state_q != tsm_pkg::ST_SCAN) |-> step_q == '0)

endmodule

// ===== sim/task_starvation_monitor_tb.sv =====
module task_starvation_monitor_tb;

	localparam int TASKS_N    = tsm_pkg::TASKS_DEF;
	localparam int WAIT_W     = tsm_pkg::WAIT_BITS_DEF;
	// cycles with no handshake at all before the run is declared hung
	localparam int IDLE_LIMIT = 20000;
	// register index with no register behind it, writes must be ignored
	localparam logic [tsm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// one result word as the block reports it
	typedef struct {
		logic signed [tsm_pkg::BARRIER_W-1:0] barrier_value;
		logic                                 is_safe;
		logic                                 is_decreasing;
		logic [tsm_pkg::LWAIT_W-1:0]          largest_wait;
		logic [tsm_pkg::WORST_W-1:0]          worst_task;
		logic                                 bound_admissible;
		logic [tsm_pkg::ROUND_W-1:0]          round_number;
	} tsm_result_t;

	// mirror of the wait counters and the round, plus the queue of result words still owed
	class starvation_scoreboard;
		logic [WAIT_W-1:0]            wait_cnt [TASKS_N];
		logic [tsm_pkg::ROUND_W-1:0]  round_cnt;
		logic [tsm_pkg::ACTIVE_W-1:0] active_tasks;
		logic [tsm_pkg::BOUND_W-1:0]  wait_bound;
		logic [tsm_pkg::ALIVE_W-1:0]  alive_tasks;
		tsm_result_t                  expected_results [$];
		int                           errors;
		int                           op_count [4];
		int                           ignored_polls;
		int                           negative_barriers;
		int                           clamped_cmds;
		int                           results_checked;
		int                           reg_writes;

		function new();
			foreach (wait_cnt[i]) wait_cnt[i] = '0;
			round_cnt = '0;
			active_tasks = '0;
			wait_bound = '0;
			alive_tasks = '0;
			errors = 0;
			foreach (op_count[i]) op_count[i] = 0;
			ignored_polls = 0;
			negative_barriers = 0;
			clamped_cmds = 0;
			results_checked = 0;
			reg_writes = 0;
		endfunction

		function int active_count();
			return (active_tasks > TASKS_N) ? TASKS_N : int'(active_tasks);
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function void apply_reg(logic [tsm_pkg::CFG_IDX_W-1:0] idx,
			logic [tsm_pkg::CFG_DATA_W-1:0] data);
			reg_writes++;
			case (idx)
				tsm_pkg::REG_ACTIVE_TASKS: active_tasks = data[tsm_pkg::ACTIVE_W-1:0];
				tsm_pkg::REG_WAIT_BOUND:   wait_bound = data[tsm_pkg::BOUND_W-1:0];
				tsm_pkg::REG_ALIVE_TASKS:  alive_tasks = data[tsm_pkg::ALIVE_W-1:0];
				default: ;
			endcase
		endfunction

		// apply one accepted command word and queue the result word it must produce
		function void note_command(tsm_pkg::op_t op, logic [tsm_pkg::SLOT_W-1:0] slot,
			logic signed [tsm_pkg::PREV_W-1:0] prev);
			tsm_result_t       r;
			int                n;
			int                worst;
			logic [WAIT_W-1:0] top;
			longint            diff;
			n = active_count();
			if (active_tasks > TASKS_N) clamped_cmds++;
			op_count[op]++;
			case (op)
				tsm_pkg::OP_CLEAR: begin
					foreach (wait_cnt[i]) wait_cnt[i] = '0;
					round_cnt = '0;
				end
				tsm_pkg::OP_POLL: begin
					if (slot < n) wait_cnt[slot] = '0;
					else ignored_polls++;
				end
				tsm_pkg::OP_ADVANCE: begin
					for (int i = 0; i < n; i++)
						if (wait_cnt[i] != '1) wait_cnt[i]++;
					round_cnt++;
				end
				default: ;
			endcase
			top = '0;
			worst = 0;
			for (int i = 0; i < n; i++) begin
				if (wait_cnt[i] > top) begin
					top = wait_cnt[i];
					worst = i;
				end
			end
			diff = longint'(wait_bound) - longint'(top);
			if (diff < 0) negative_barriers++;
			r.barrier_value = diff[tsm_pkg::BARRIER_W-1:0];
			r.is_safe = (diff > 0);
			r.is_decreasing = (diff < longint'(prev));
			r.largest_wait = top[tsm_pkg::LWAIT_W-1:0];
			r.worst_task = worst[tsm_pkg::WORST_W-1:0];
			r.bound_admissible = (wait_bound != 0) && (alive_tasks <= n);
			r.round_number = round_cnt;
			expected_results.push_back(r);
		endfunction

		function void compare_field(string name, logic signed [32:0] exp_val,
			logic signed [32:0] act_val);
			if (act_val !== exp_val) begin
				errors++;
				$display("%0t: %s expected %0d got %0d", $time, name, exp_val, act_val);
			end
		endfunction

		function void check_result(tsm_result_t act);
			tsm_result_t e;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: result word with nothing expected, barrier_value %0d",
					$time, act.barrier_value);
				return;
			end
			e = expected_results.pop_front();
			results_checked++;
			compare_field("barrier_value", e.barrier_value, act.barrier_value);
			compare_field("is_safe", e.is_safe, act.is_safe);
			compare_field("is_decreasing", e.is_decreasing, act.is_decreasing);
			compare_field("largest_wait", e.largest_wait, act.largest_wait);
			compare_field("worst_task", e.worst_task, act.worst_task);
			compare_field("bound_admissible", e.bound_admissible, act.bound_admissible);
			compare_field("round_number", e.round_number, act.round_number);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	tsm_cmd_if cmd();
	tsm_rsp_if rsp();
	tsm_cfg_if cfg();

	task_starvation_monitor DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	starvation_scoreboard sb = new();

	tsm_result_t seen_result;
	int          rsp_count = 0;
	int          idle_cycles = 0;
	int          long_holds = 0;

	// free-running clock, 10 units per period
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// gap length: mostly none or short, now and then long enough to span a whole scan
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 80) return $urandom_range(1, 4);
		if (r < 95) return $urandom_range(5, 70);
		return $urandom_range(71, 200);
	endfunction

	// sampling at the rising edge: handshakes feed the scoreboard, watchdog counts dead cycles
	always @(posedge clk) begin
		if (arst_n) begin
			// result first, it always belongs to an older command word
			if (rsp.valid && rsp.ready) begin
				seen_result.barrier_value = rsp.barrier_value;
				seen_result.is_safe = rsp.is_safe;
				seen_result.is_decreasing = rsp.is_decreasing;
				seen_result.largest_wait = rsp.largest_wait;
				seen_result.worst_task = rsp.worst_task;
				seen_result.bound_admissible = rsp.bound_admissible;
				seen_result.round_number = rsp.round_number;
				sb.check_result(seen_result);
				rsp_count++;
			end
			if (cmd.valid && cmd.ready)
				sb.note_command(cmd.op, cmd.task_slot, cmd.previous_value);
			if (cfg.valid && cfg.ready)
				sb.apply_reg(cfg.index, cfg.data);
			if ((rsp.valid && rsp.ready) || (cmd.valid && cmd.ready) ||
				(cfg.valid && cfg.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// result side: random stalls with quiet stretches, plus long holds that back the block up
	initial begin
		int stall_left;
		int stall_pct;
		int cycle;
		int hold_at;
		rsp.ready = 1'b0;
		stall_left = 0;
		stall_pct = 20;
		cycle = 0;
		hold_at = 150;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cycle++;
			// change the stall rate now and then, zero gives stretches with no stalls at all
			if (cycle % 300 == 0) begin
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 15;
					default: stall_pct = 40;
				endcase
			end
			if (rsp_count >= hold_at) begin
				// long hold: sender keeps offering, so the block fills and stops taking words
				rsp.ready <= 1'b0;
				hold_at += 900;
				long_holds++;
				repeat (500) @(negedge clk);
			end else if (stall_left > 0) begin
				rsp.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp.ready <= 1'b1;
				if ($urandom_range(0, 99) < stall_pct) stall_left = pick_gap();
			end
		end
	end

	// one command word, held until taken; returns at the following falling edge
	task automatic send_word(input tsm_pkg::op_t op, input logic [tsm_pkg::SLOT_W-1:0] slot,
		input logic signed [tsm_pkg::PREV_W-1:0] prev);
		cmd.valid <= 1'b1;
		cmd.op <= op;
		cmd.task_slot <= slot;
		cmd.previous_value <= prev;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic cmd_gap(input int n);
		if (n > 0) begin
			cmd.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// stop sending and wait for every owed result word, after this the block is idle
	task automatic drain();
		cmd.valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0) @(negedge clk);
	endtask

	// register write, only called while the block is idle
	task automatic cfg_write(input logic [tsm_pkg::CFG_IDX_W-1:0] idx,
		input logic [tsm_pkg::CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		@(negedge clk);
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int                                sent;
		int                                len;
		int                                n;
		bit                                quiet;
		tsm_pkg::op_t                      op;
		logic [tsm_pkg::SLOT_W-1:0]        slot;
		logic signed [tsm_pkg::PREV_W-1:0] prev;
		logic [tsm_pkg::CFG_DATA_W-1:0]    d;

		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.op = tsm_pkg::OP_EVAL;
		cmd.task_slot = '0;
		cmd.previous_value = '0;
		cfg.valid = 1'b0;
		cfg.index = tsm_pkg::REG_ACTIVE_TASKS;
		cfg.data = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// four tasks, bound of three: barrier walks down through zero into negative
		cfg_write(tsm_pkg::REG_ACTIVE_TASKS, 16'd4);
		cfg_write(tsm_pkg::REG_WAIT_BOUND, 16'd3);
		cfg_write(tsm_pkg::REG_ALIVE_TASKS, 16'd4);
		send_word(tsm_pkg::OP_EVAL, 6'd0, 17'd0);
		send_word(tsm_pkg::OP_ADVANCE, 6'd0, 17'd3);
		send_word(tsm_pkg::OP_ADVANCE, 6'd0, 17'd1);
		send_word(tsm_pkg::OP_ADVANCE, 6'd0, 17'd0);
		send_word(tsm_pkg::OP_ADVANCE, 6'd0, 17'h1FFFF);
		// poll the worst task, then the last active one, then two inactive slots
		send_word(tsm_pkg::OP_POLL, 6'd0, 17'd0);
		send_word(tsm_pkg::OP_POLL, 6'd3, 17'd0);
		send_word(tsm_pkg::OP_POLL, 6'd4, 17'd0);
		send_word(tsm_pkg::OP_POLL, 6'd63, 17'd0);
		// previous value at both ends of its range
		send_word(tsm_pkg::OP_EVAL, 6'd0, 17'h10000);
		send_word(tsm_pkg::OP_EVAL, 6'h3F, 17'h0FFFF);

		// count above capacity with junk in the upper data bits, widest bound;
		// old counters of tasks 0..3 come back into the scan
		drain();
		cfg_write(tsm_pkg::REG_ACTIVE_TASKS, 16'hFFE4);
		cfg_write(tsm_pkg::REG_WAIT_BOUND, 16'hFFFF);
		cfg_write(tsm_pkg::REG_ALIVE_TASKS, 16'd64);
		send_word(tsm_pkg::OP_ADVANCE, 6'd0, 17'd0);
		send_word(tsm_pkg::OP_POLL, 6'd63, 17'd0);
		send_word(tsm_pkg::OP_ADVANCE, 6'd0, 17'h0FFFF);
		send_word(tsm_pkg::OP_EVAL, 6'd0, 17'h10000);

		// no active tasks, zero bound, alive count above any task count, unused index
		drain();
		cfg_write(tsm_pkg::REG_ACTIVE_TASKS, 16'd0);
		cfg_write(tsm_pkg::REG_WAIT_BOUND, 16'd0);
		cfg_write(tsm_pkg::REG_ALIVE_TASKS, 16'd127);
		cfg_write(REG_UNUSED, 16'hFFFF);
		send_word(tsm_pkg::OP_ADVANCE, 6'd0, 17'd0);
		send_word(tsm_pkg::OP_POLL, 6'd0, 17'd0);
		send_word(tsm_pkg::OP_CLEAR, 6'd0, 17'd1);

		// full task count, bound of one
		drain();
		cfg_write(tsm_pkg::REG_ACTIVE_TASKS, 16'd64);
		cfg_write(tsm_pkg::REG_WAIT_BOUND, 16'd1);
		cfg_write(tsm_pkg::REG_ALIVE_TASKS, 16'd0);
		send_word(tsm_pkg::OP_ADVANCE, 6'd0, 17'd0);
		send_word(tsm_pkg::OP_CLEAR, 6'd0, 17'd0);
		send_word(tsm_pkg::OP_EVAL, 6'd0, 17'd0);

		// random phases: new settings while idle, then a run of random command words
		sent = 0;
		while (sent < 2000) begin
			drain();
			if ($urandom_range(0, 9) < 8) begin
				case ($urandom_range(0, 5))
					0: d = 16'd0;
					1: d = 16'd64;
					2: d = 16'($urandom_range(65, 127));
					3: d = 16'($urandom_range(1, 64));
					default: d = 16'($urandom_range(1, 8));
				endcase
				if ($urandom_range(0, 9) == 0) d[15:7] = 9'($urandom);
				cfg_write(tsm_pkg::REG_ACTIVE_TASKS, d);
			end
			if ($urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 5))
					0: d = 16'd0;
					1: d = 16'hFFFF;
					2: d = 16'($urandom);
					default: d = 16'($urandom_range(1, 60));
				endcase
				cfg_write(tsm_pkg::REG_WAIT_BOUND, d);
			end
			if ($urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 2))
					0: d = 16'($urandom_range(0, 127));
					1: d = 16'(sb.active_tasks);
					default: d = 16'(sb.active_tasks) + 16'd1;
				endcase
				if ($urandom_range(0, 9) == 0) d[15:7] = 9'($urandom);
				cfg_write(tsm_pkg::REG_ALIVE_TASKS, d);
			end
			if ($urandom_range(0, 19) == 0) cfg_write(REG_UNUSED, 16'($urandom));

			quiet = ($urandom_range(0, 3) == 0);
			len = $urandom_range(10, 150);
			n = sb.active_count();
			for (int k = 0; k < len && sent < 2000; k++) begin
				// clears kept rare so counters climb past small bounds
				case ($urandom_range(0, 99)) inside
					[0:2]:   op = tsm_pkg::OP_CLEAR;
					[3:39]:  op = tsm_pkg::OP_POLL;
					[40:79]: op = tsm_pkg::OP_ADVANCE;
					default: op = tsm_pkg::OP_EVAL;
				endcase
				if (n > 0 && $urandom_range(0, 99) < 85) slot = 6'($urandom_range(0, n - 1));
				else slot = 6'($urandom_range(0, 63));
				// previous value: raw bits, near the current bound, or an extreme
				case ($urandom_range(0, 9))
					0, 1, 2, 3: prev = 17'($urandom_range(0, 17'h1FFFF));
					8:          prev = 17'h10000;
					9:          prev = 17'h0FFFF;
					default:    prev = 17'(int'(sb.wait_bound) - int'($urandom_range(0, 60)));
				endcase
				send_word(op, slot, prev);
				sent++;
				if (!quiet) cmd_gap(pick_gap());
			end
		end

		drain();
		repeat (2 * (TASKS_N + 2)) @(negedge clk);

		$display("covered %0d clears, %0d polls (%0d to inactive slots), %0d advances,",
			sb.op_count[tsm_pkg::OP_CLEAR], sb.op_count[tsm_pkg::OP_POLL], sb.ignored_polls,
			sb.op_count[tsm_pkg::OP_ADVANCE]);
		$display("%0d evaluations, %0d results checked, %0d negative barriers,",
			sb.op_count[tsm_pkg::OP_EVAL], sb.results_checked, sb.negative_barriers);
		$display("%0d under clamped count, %0d reg writes, %0d long holds",
			sb.clamped_cmds, sb.reg_writes, long_holds);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			if (sb.pending() != 0) $display("%0d result words never arrived", sb.pending());
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tsm_pkg.sv
rtl/tsm_if.sv
rtl/tsm_cell.sv
rtl/tsm_head.sv
rtl/task_starvation_monitor.sv
sim/task_starvation_monitor_tb.sv
